// File: sv/oks_pkg.sv
// oks_pkg: constants, types and codes shared by the ordered key set block
// used by the channel interfaces, the storage cell and the top level
`default_nettype none

package oks_pkg;

  localparam int CAPACITY  = 64;
  localparam int KEY_WIDTH = 32;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int OPC_W     = 3;
  localparam int STAT_W    = 2;
  localparam int FIELD_W   = 32;

  typedef logic [KEY_WIDTH-1:0] key_t;
  typedef logic [FIELD_W-1:0]   field_key_t;
  typedef logic [CNT_W-1:0]     count_t;
  typedef logic [OPC_W-1:0]     opcode_t;
  typedef logic [STAT_W-1:0]    status_t;

  // opcodes
  localparam opcode_t OP_INSERT   = 3'd0;
  localparam opcode_t OP_REMOVE   = 3'd1;
  localparam opcode_t OP_CONTAINS = 3'd2;
  localparam opcode_t OP_SMALLEST = 3'd3;
  localparam opcode_t OP_LARGEST  = 3'd4;
  localparam opcode_t OP_PRED     = 3'd5;
  localparam opcode_t OP_SUCC     = 3'd6;

  // result status
  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_MISS = 2'd1;
  localparam status_t ST_FULL = 2'd2;

  // per cell update command
  typedef logic [1:0] cell_cmd_t;
  localparam cell_cmd_t CELL_HOLD  = 2'd0;
  localparam cell_cmd_t CELL_LOAD  = 2'd1;
  localparam cell_cmd_t CELL_LEFT  = 2'd2;
  localparam cell_cmd_t CELL_RIGHT = 2'd3;

  // compare flags a cell reports against the broadcast key
  typedef struct packed {
    logic lt;
    logic eq;
  } cell_flags_t;

endpackage

`default_nettype wire

// File: sv/oks_if.sv
// oks_if: valid/ready channel interfaces for the ordered key set block
// depends on oks_pkg for field types
`default_nettype none

interface oks_in_if;
  import oks_pkg::*;

  logic    valid;
  logic    ready;
  opcode_t opcode;
  field_key_t key;

  modport source (output valid, output opcode, output key, input ready);
  modport sink   (input valid, input opcode, input key, output ready);
endinterface

interface oks_out_if;
  import oks_pkg::*;

  logic       valid;
  logic       ready;
  status_t    status;
  field_key_t result_key;
  count_t     element_count;

  modport source (output valid, output status, output result_key, output element_count,
                  input ready);
  modport sink   (input valid, input status, input result_key, input element_count,
                  output ready);
endinterface

`default_nettype wire

// File: sv/oks_cell.sv
// oks_cell: one storage cell of the sorted key chain
// depends on oks_pkg; holds one key, compares it against the broadcast key
`default_nettype none

module oks_cell (
  input  wire logic                clk,
  input  wire oks_pkg::key_t       key_i,
  input  wire oks_pkg::key_t       left_key,
  input  wire oks_pkg::key_t       right_key,
  input  wire oks_pkg::cell_cmd_t  cmd,
  output oks_pkg::key_t            key_o,
  output oks_pkg::cell_flags_t     flags_o
);
  import oks_pkg::*;

  key_t        key_r, key_nxt;
  cell_flags_t flags_r, flags_nxt;

  always_comb begin
    case (cmd)
      CELL_HOLD:  key_nxt = key_r;
      CELL_LOAD:  key_nxt = key_i;
      CELL_LEFT:  key_nxt = left_key;
      CELL_RIGHT: key_nxt = right_key;
      default:    key_nxt = key_r;
    endcase
    flags_nxt.lt = (key_r < key_i);
    flags_nxt.eq = (key_r == key_i);
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    flags_r <= flags_nxt;
  end

  assign key_o   = key_r;
  assign flags_o = flags_r;

endmodule

`default_nettype wire

// File: sv/ordered_key_set_unit.sv
// ordered_key_set_unit: top level of the ordered key set block
// depends on oks_pkg, oks_if (channel interfaces) and oks_cell
//
// usage
//   in_ch carries one operation per transfer: opcode and key. out_ch returns
//   one result per operation: status, result_key and element_count.
//   the keys live in a row of CAPACITY cells kept in ascending unsigned order;
//   signed ordering is a rotated view of that row, so the register can change
//   without touching the stored keys.
// timing
//   an operation passes through a compare phase after its transfer, in which every
//   cell compares its key with the broadcast key and registers the flags, and then
//   an execute phase, in which the flags select the answer, the cells shift and
//   the result is written into the output register. a new operation is taken in
//   the execute cycle of the previous one, so its compare phase follows directly
//   on that execute phase.
// stalls and reset
//   the output register holds a result until out_ch.ready; a following item
//   waits in its execute cycle while the output register is still occupied.
//   synchronous active-low reset empties the set and selects unsigned order.
//   the apb-style register (signed_order at address 0) is written with psel,
//   penable and pwrite high; pready is always high.
`default_nettype none

module ordered_key_set_unit (
  input  wire logic  clk,
  input  wire logic  rst_n,
  oks_in_if.sink     in_ch,
  oks_out_if.source  out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import oks_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_CMP  = 2'd1;
  localparam logic [1:0] PH_EXE  = 2'd2;

  localparam int MSB = KEY_WIDTH - 1;

  // control state
  logic [1:0] phase_r, phase_nxt;
  count_t     count_r, count_nxt;
  logic       signed_order_r;
  logic       out_valid_r, out_valid_nxt;

  // operation held during compare and execute
  opcode_t op_r;
  key_t    key_r;

  // result register
  status_t    out_status_r, out_status_nxt;
  field_key_t out_key_r, out_key_nxt;
  count_t     out_count_r;

  // cell row
  key_t        cell_key   [CAPACITY];
  cell_flags_t cell_flags [CAPACITY];
  cell_cmd_t   cmd        [CAPACITY];

  // per cell flag vectors
  logic [CAPACITY-1:0] v, lt, eq, neg, nn;
  logic [CAPACITY-1:0] last_lt, last_v, first_neg, last_nn, after_eq;
  logic [CAPACITY-1:0] lt_prev, load_pos, sel, first_cell;

  logic out_free, in_fire, exe_fire;
  logic found, any_neg, full, k_neg;
  logic do_insert, do_remove;
  key_t rkey;

  // ---------------- register port ----------------
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {31'd0, signed_order_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      signed_order_r <= 1'b0;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      signed_order_r <= pwdata[0];
    end
  end

  // ---------------- handshake ----------------
  assign out_free = !out_valid_r || out_ch.ready;
  assign exe_fire = (phase_r == PH_EXE) && out_free;
  assign in_ch.ready = (phase_r == PH_IDLE) || exe_fire;
  assign in_fire = in_ch.valid && in_ch.ready;

  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_IDLE: if (in_fire) phase_nxt = PH_CMP;
      PH_CMP:  phase_nxt = PH_EXE;
      PH_EXE: begin
        if (exe_fire) phase_nxt = in_fire ? PH_CMP : PH_IDLE;
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= in_ch.opcode;
      key_r <= in_ch.key[KEY_WIDTH-1:0];
    end
  end

  // ---------------- cell row ----------------
  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    key_t left_k, right_k;
    if (j == 0) begin : g_first
      assign left_k = cell_key[j];
    end else begin : g_left
      assign left_k = cell_key[j-1];
    end
    if (j == CAPACITY - 1) begin : g_last
      assign right_k = cell_key[j];
    end else begin : g_right
      assign right_k = cell_key[j+1];
    end

    oks_cell u_cell (
      .clk       (clk),
      .key_i     (key_r),
      .left_key  (left_k),
      .right_key (right_k),
      .cmd       (cmd[j]),
      .key_o     (cell_key[j]),
      .flags_o   (cell_flags[j])
    );

    // occupied cells form a prefix of the row
    assign v[j]   = (count_r > CNT_W'(j));
    assign lt[j]  = v[j] && cell_flags[j].lt;
    assign eq[j]  = v[j] && cell_flags[j].eq;
    assign neg[j] = v[j] && cell_key[j][MSB];
    assign nn[j]  = v[j] && !cell_key[j][MSB];
  end

  // one-hot markers from neighbor flags
  assign last_lt    = lt & ~(lt >> 1);              // cell at pos-1
  assign last_v     = v & ~(v >> 1);                // cell n-1
  assign first_neg  = neg & ~(neg << 1);            // first key with top bit set
  assign last_nn    = nn & ~(nn >> 1);              // last key with top bit clear
  assign after_eq   = eq << 1;                      // cell after the match
  assign lt_prev    = {lt[CAPACITY-2:0], 1'b1};
  assign load_pos   = ~lt & lt_prev;                // insertion point
  assign first_cell = {{(CAPACITY-1){1'b0}}, 1'b1};

  assign found   = |eq;
  assign any_neg = |neg;
  assign full    = (count_r == CNT_W'(CAPACITY));
  assign k_neg   = signed_order_r && key_r[MSB];

  // answer selection
  always_comb begin
    sel            = '0;
    out_status_nxt = ST_MISS;
    do_insert      = 1'b0;
    do_remove      = 1'b0;
    case (op_r)
      OP_INSERT: begin
        if (found) begin
          out_status_nxt = ST_MISS;
        end else if (full) begin
          out_status_nxt = ST_FULL;
        end else begin
          out_status_nxt = ST_OK;
          do_insert      = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (found) begin
          out_status_nxt = ST_OK;
          do_remove      = 1'b1;
        end
      end
      OP_CONTAINS: out_status_nxt = found ? ST_OK : ST_MISS;
      OP_SMALLEST: begin
        if (v[0]) sel = (signed_order_r && any_neg) ? first_neg : first_cell;
      end
      OP_LARGEST: begin
        sel = (signed_order_r && nn[0]) ? last_nn : last_v;
      end
      OP_PRED: begin
        if (found) begin
          if (!signed_order_r) begin
            if (lt[0]) sel = last_lt;
          end else if (k_neg) begin
            // negatives run from the split up to the match
            if (|(last_lt & neg)) sel = last_lt;
          end else begin
            // below the smallest non-negative key comes the largest negative
            if (lt[0]) sel = last_lt;
            else if (any_neg) sel = last_v;
          end
        end
      end
      OP_SUCC: begin
        if (found) begin
          if (!signed_order_r) begin
            if (|(after_eq & v)) sel = after_eq;
          end else if (k_neg) begin
            // past the largest negative key wraps to the smallest non-negative
            if (|(after_eq & v)) sel = after_eq;
            else if (nn[0]) sel = first_cell;
          end else begin
            if (|(after_eq & nn)) sel = after_eq;
          end
        end
      end
      default: out_status_nxt = ST_MISS;
    endcase
    if (op_r == OP_SMALLEST || op_r == OP_LARGEST || op_r == OP_PRED ||
        op_r == OP_SUCC) begin
      out_status_nxt = (|sel) ? ST_OK : ST_MISS;
    end
  end

  // and-or mux over the row
  always_comb begin
    rkey = '0;
    for (int j = 0; j < CAPACITY; j++) begin
      rkey = rkey | (cell_key[j] & {KEY_WIDTH{sel[j]}});
    end
    out_key_nxt = field_key_t'(rkey);
  end

  // cell shift commands
  always_comb begin
    for (int j = 0; j < CAPACITY; j++) begin
      cmd[j] = CELL_HOLD;
      if (exe_fire && do_insert) begin
        if (load_pos[j])  cmd[j] = CELL_LOAD;
        else if (!lt[j]) cmd[j] = CELL_LEFT;
      end else if (exe_fire && do_remove) begin
        if (!lt[j]) cmd[j] = CELL_RIGHT;
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (exe_fire && do_insert) count_nxt = count_r + CNT_W'(1);
    else if (exe_fire && do_remove) count_nxt = count_r - CNT_W'(1);
  end

  assign out_valid_nxt = exe_fire ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (exe_fire) begin
      out_status_r <= out_status_nxt;
      out_key_r    <= out_key_nxt;
      out_count_r  <= count_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.result_key    = out_key_r;
  assign out_ch.element_count = out_count_r;

endmodule

`default_nettype wire
